[hw/rtl/assert_macros.svh]
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst, cond) \
  label: assert property (@(posedge clk) disable iff (rst) cond) \
    else $error("assertion failed");
// Condition that must hold in the cycle after a trigger, outside reset.
`define ASSERT_NEXT(label, clk, rst, trig, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) \
    else $error("assertion failed");
`endif

[hw/rtl/srn_pkg.sv]
package srn_pkg;
  localparam int NInputsDef    = 16;
  localparam int NLateralDef   = 16;
  localparam int MaxKernelsDef = 32;

  typedef enum logic [2:0] {
    REG_KAPPA = 3'd0, REG_DECAY = 3'd1, REG_MINAMP = 3'd2, REG_REST = 3'd3,
    REG_THRESH = 3'd4, REG_REFR = 3'd5, REG_OWN = 3'd6, REG_DIS = 3'd7
  } reg_idx_t;

  localparam logic CMD_TICK  = 1'b0;
  localparam logic CMD_WEIGHT = 1'b1;

  // Controller to datapath commands.
  typedef struct packed {
    logic clear_sum;   // start of a tick
    logic ins_req;     // insert one kernel from the current source
    logic scan_step;   // decay and accumulate the slot under the pointer
    logic fire_clear;  // drop all kernels
  } srn_cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic ins_full;
  } srn_sts_t;

  function automatic logic signed [15:0] sat16(input logic signed [39:0] v);
    if (v > 40'sd32767) return 16'sh7FFF;
    if (v < -40'sd32768) return 16'sh8000;
    return v[15:0];
  endfunction
endpackage

[hw/rtl/spike_response_neuron.sv]
// One spiking neuron, one time tick per input beat. A tick first offers each
// input and lateral channel to the kernel store, then makes the decay-and-sum
// walk over the store (one slot per cycle through a single multiplier), then
// tests firing and registers the result. Weight writes and ignored refractory
// ticks skip the offer, the walk and the firing test. A result waits in an
// output register until it is taken; the next input beat is accepted once
// the result register is free.
`include "assert_macros.svh"
module spike_response_neuron import srn_pkg::*; #(
  parameter int NUM_SYN     = NInputsDef,
  parameter int NUM_LAT     = NLateralDef,
  parameter int MAX_KERNELS = MaxKernelsDef
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [23:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               cmd,
  input  logic [15:0]        input_spikes,
  input  logic [15:0]        lateral_spikes,
  input  logic [3:0]         weight_index,
  input  logic signed [15:0] weight_value,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               spike,
  output logic               refractory,
  output logic signed [23:0] potential,
  output logic [5:0]         kernel_count,
  output logic               dropped
);
  localparam int AW = $clog2(MAX_KERNELS);
  localparam int CW = $clog2(MAX_KERNELS + 1);
  localparam int LW = (NUM_LAT > 1) ? $clog2(NUM_LAT) : 1;

  logic [15:0] kappa_zero, decay_factor, min_amplitude;
  logic signed [23:0] rest_potential;
  logic [22:0] threshold;
  logic [7:0]  refractory_ticks;
  logic [3:0]  own_index;
  logic        disabled;

  logic [15:0] item_ispk, item_lspk;
  logic signed [15:0] lat_w [NUM_LAT];
  logic signed [15:0] lat_w_sel;
  logic signed [15:0] new_amp;
  logic signed [31:0] lat_prod;
  logic signed [33:0] pot;
  logic        in_go, busy, done, active, drop_f, spiked, in_refr, fire_now;
  logic [4:0]  src;
  logic [AW-1:0] ptr;
  logic signed [31:0] sum;
  logic [CW-1:0] live_cnt;
  srn_cmd_t    dp_cmd;
  srn_sts_t    dp_sts;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      kappa_zero       <= 16'd4096;
      decay_factor     <= 16'd59299;
      min_amplitude    <= 16'd41;
      rest_potential   <= '0;
      threshold        <= 23'd8192;
      refractory_ticks <= 8'd5;
      own_index        <= '0;
      disabled         <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (reg_idx_t'(cfg_index))
        REG_KAPPA:  kappa_zero       <= cfg_data[15:0];
        REG_DECAY:  decay_factor     <= cfg_data[15:0];
        REG_MINAMP: min_amplitude    <= cfg_data[15:0];
        REG_REST:   rest_potential   <= cfg_data;
        REG_THRESH: threshold        <= cfg_data[22:0];
        REG_REFR:   refractory_ticks <= cfg_data[7:0];
        REG_OWN:    own_index        <= cfg_data[3:0];
        REG_DIS:    disabled         <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // The cycle in which the result register loads also holds off the input.
  assign in_stall = busy || done || out_valid;
  assign in_go    = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (in_go) begin
      item_ispk <= input_spikes;
      item_lspk <= lateral_spikes;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int m = 0; m < NUM_LAT; m++) lat_w[m] <= '0;
    end else if (in_go && cmd == CMD_WEIGHT && 32'(weight_index) < NUM_LAT) begin
      lat_w[LW'(weight_index)] <= weight_value;
    end
  end

  assign lat_w_sel = (32'(src[3:0]) < NUM_LAT) ? lat_w[LW'(src[3:0])] : 16'sd0;
  assign lat_prod  = $signed({16'd0, kappa_zero}) * 32'(lat_w_sel) + 32'sd8192;
  assign new_amp   = src[4] ? sat16(40'(lat_prod >>> 14))
                            : (kappa_zero[15] ? 16'sh7FFF : $signed(kappa_zero));

  assign pot      = 34'(sum) + 34'(rest_potential);
  assign fire_now = active && !disabled && (pot >= $signed({11'd0, threshold}));

  srn_control #(
    .NUM_SYN(NUM_SYN), .NUM_LAT(NUM_LAT), .MAX_KERNELS(MAX_KERNELS)
  ) u_ctrl (
    .clk, .rst, .in_go, .item_cmd(cmd),
    .item_ispk, .item_lspk, .own_index, .refractory_ticks, .fire_now,
    .sts(dp_sts), .cmd_out(dp_cmd), .ptr, .src, .busy, .done, .active,
    .dropped(drop_f), .spiked, .in_refr
  );

  srn_datapath #(.MAX_KERNELS(MAX_KERNELS)) u_dp (
    .clk, .rst, .cmd_in(dp_cmd), .ptr, .new_amp, .decay_factor, .min_amplitude,
    .sts(dp_sts), .sum, .live_cnt
  );

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (done) out_valid <= 1'b1;
    else if (!out_stall) out_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (done) begin
      spike        <= spiked;
      refractory   <= in_refr;
      dropped      <= drop_f;
      kernel_count <= 6'(live_cnt);
      if (!active) potential <= '0;
      else if (pot > 34'sd8388607) potential <= 24'sh7FFFFF;
      else if (pot < -34'sd8388608) potential <= 24'sh800000;
      else potential <= pot[23:0];
    end
  end

  `ASSERT_IMPL(a_no_accept_busy, clk, rst, busy |-> in_stall)
  `ASSERT_IMPL(a_spike_refr, clk, rst, (out_valid && spike) |-> refractory)
  `ASSERT_IMPL(a_spike_clears, clk, rst, (out_valid && spike) |-> (kernel_count == 6'd0))
  `ASSERT_NEXT(a_done_idle, clk, rst, done, out_valid)
endmodule

[hw/rtl/srn_datapath.sv]
module srn_datapath import srn_pkg::*; #(
  parameter int MAX_KERNELS = MaxKernelsDef
) (
  input  logic                          clk,
  input  logic                          rst,
  input  srn_cmd_t                      cmd_in,
  input  logic [$clog2(MAX_KERNELS)-1:0] ptr,
  input  logic signed [15:0]            new_amp,
  input  logic [15:0]                   decay_factor,
  input  logic [15:0]                   min_amplitude,
  output srn_sts_t                      sts,
  output logic signed [31:0]            sum,
  output logic [$clog2(MAX_KERNELS+1)-1:0] live_cnt
);
  localparam int AW = $clog2(MAX_KERNELS);
  localparam int CW = $clog2(MAX_KERNELS + 1);

  logic signed [15:0] amp [MAX_KERNELS];
  logic [MAX_KERNELS-1:0] live;
  logic [AW-1:0] free_idx;
  logic          free_any;
  logic signed [33:0] prod;
  logic signed [15:0] dec;
  logic [15:0]        mag;
  logic               keep;

  always_comb begin
    free_idx = '0;
    free_any = 1'b0;
    for (int k = MAX_KERNELS - 1; k >= 0; k--) begin
      if (!live[k]) begin
        free_idx = AW'(k);
        free_any = 1'b1;
      end
    end
  end

  assign sts.ins_full = !free_any;
  // Round to nearest with ties up: add half then arithmetic shift.
  assign prod = (34'(amp[ptr]) * $signed({18'd0, decay_factor})) + 34'sd32768;
  assign dec  = sat16(40'(prod >>> 16));
  assign mag  = dec[15] ? 16'(-dec) : dec;
  assign keep = mag >= min_amplitude;

  always_ff @(posedge clk) begin
    if (cmd_in.ins_req && free_any) amp[free_idx] <= new_amp;
    else if (cmd_in.scan_step && live[ptr]) amp[ptr] <= dec;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      live     <= '0;
      live_cnt <= '0;
      sum      <= '0;
    end else begin
      if (cmd_in.clear_sum) sum <= '0;
      if (cmd_in.fire_clear) begin
        live     <= '0;
        live_cnt <= '0;
      end else if (cmd_in.ins_req && free_any) begin
        live[free_idx] <= 1'b1;
        live_cnt       <= live_cnt + CW'(1);
      end else if (cmd_in.scan_step && live[ptr]) begin
        if (keep) sum <= sum + 32'(dec);
        else begin
          live[ptr] <= 1'b0;
          live_cnt  <= live_cnt - CW'(1);
        end
      end
    end
  end
endmodule

[hw/rtl/srn_control.sv]
module srn_control import srn_pkg::*; #(
  parameter int NUM_SYN     = NInputsDef,
  parameter int NUM_LAT     = NLateralDef,
  parameter int MAX_KERNELS = MaxKernelsDef
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_go,
  input  logic        item_cmd,
  input  logic [15:0] item_ispk,
  input  logic [15:0] item_lspk,
  input  logic [3:0]  own_index,
  input  logic [7:0]  refractory_ticks,
  input  logic        fire_now,
  input  srn_sts_t    sts,
  output srn_cmd_t    cmd_out,
  output logic [$clog2(MAX_KERNELS)-1:0] ptr,
  output logic [4:0]  src,
  output logic        busy,
  output logic        done,
  output logic        active,
  output logic        dropped,
  output logic        spiked,
  output logic        in_refr
);
  localparam int AW = $clog2(MAX_KERNELS);
  localparam int NI = (NUM_SYN < 16) ? NUM_SYN : 16;
  localparam int NL = (NUM_LAT < 16) ? NUM_LAT : 16;

  typedef enum logic [2:0] {S_IDLE, S_INS, S_SCAN, S_FIRE, S_DONE} state_t;
  state_t state;
  logic [7:0] refr_cnt;
  logic [7:0] refr_cnt_next;
  logic       src_on;

  // Sources 0..15 are input synapses, 16..31 lateral neurons.
  always_comb begin
    src_on = 1'b0;
    if (!src[4]) src_on = (32'(src[3:0]) < NI) && item_ispk[src[3:0]];
    else src_on = (32'(src[3:0]) < NL) && item_lspk[src[3:0]] && (src[3:0] != own_index);
  end

  assign refr_cnt_next = refr_cnt + 8'd1;

  always_comb begin
    cmd_out = '0;
    cmd_out.ins_req   = (state == S_INS) && src_on;
    cmd_out.scan_step = (state == S_SCAN);
    cmd_out.fire_clear = (state == S_FIRE) && fire_now;
    cmd_out.clear_sum = in_go;
  end

  assign busy = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      refr_cnt <= '0;
      in_refr  <= 1'b0;
      ptr      <= '0;
      src      <= '0;
      done     <= 1'b0;
      active   <= 1'b0;
      dropped  <= 1'b0;
      spiked   <= 1'b0;
    end else begin
      done <= (state == S_DONE);
      case (state)
        S_IDLE: begin
          if (in_go) begin
            dropped <= 1'b0;
            spiked  <= 1'b0;
            src     <= '0;
            ptr     <= '0;
            if (item_cmd == CMD_WEIGHT) begin
              active <= 1'b0;
              state  <= S_DONE;
            end else if (in_refr) begin
              if (refr_cnt_next == refractory_ticks) begin
                in_refr  <= 1'b0;
                refr_cnt <= '0;
                active   <= 1'b1;
                state    <= S_INS;
              end else begin
                refr_cnt <= refr_cnt_next;
                active   <= 1'b0;
                state    <= S_DONE;
              end
            end else begin
              active <= 1'b1;
              state  <= S_INS;
            end
          end
        end
        S_INS: begin
          if (src_on && sts.ins_full) dropped <= 1'b1;
          src <= src + 5'd1;
          if (src == 5'd31) state <= S_SCAN;
        end
        S_SCAN: begin
          ptr <= ptr + AW'(1);
          if (ptr == AW'(MAX_KERNELS - 1)) state <= S_FIRE;
        end
        S_FIRE: begin
          if (fire_now) begin
            spiked   <= 1'b1;
            in_refr  <= 1'b1;
            refr_cnt <= '0;
          end
          state <= S_DONE;
        end
        S_DONE: begin
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
